// ----- rtl/rmf_pkg.sv -----
// Shared constants, state encoding and controller/datapath interface types.
package rmf_pkg;

	localparam int MAX_SIDE = 16;
	localparam int SIDE_W   = 5;
	localparam int WORD_W   = 31;
	localparam int COORD_W  = $clog2(MAX_SIDE);
	localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int ENTRY_W  = 2 * COORD_W;
	localparam int DIAG_W   = COORD_W + 1;
	localparam int BIT_W    = $clog2(WORD_W);

	// APB register map
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic [PADDR_W-3:0] REG_MATRIX_SIDE = '0;
	localparam logic [SIDE_W-1:0]  SIDE_RESET      = SIDE_W'(4);

	typedef enum logic [2:0] {
		ST_START,
		ST_FILL,
		ST_IDLE,
		ST_DIV,
		ST_PICK,
		ST_SEL,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic fill_start;
		logic fill_step;
		logic load;
		logic div_step;
		logic read_pick;
		logic hold_pick;
		logic shift_step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_done;
		logic div_done;
		logic shift_done;
		logic out_full;
		logic out_taken;
		logic emit_last;
	} dp_stat_t;

endpackage

// ----- rtl/rmf_ctrl.sv -----
// Sequencer for list reload, remainder, pick, gap close and result transfer.
module rmf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr,
	input  logic              draw_valid,
	input  rmf_pkg::dp_stat_t stat,
	output logic              draw_stall,
	output rmf_pkg::dp_cmd_t  cmd
);

	rmf_pkg::state_t state_q;
	rmf_pkg::state_t state_nxt;
	logic            can_emit;

	assign can_emit = !stat.out_full || stat.out_taken;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmf_pkg::ST_START;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rmf_pkg::ST_START: state_nxt = rmf_pkg::ST_FILL;
			rmf_pkg::ST_FILL: begin
				if (stat.fill_done) state_nxt = rmf_pkg::ST_IDLE;
			end
			rmf_pkg::ST_IDLE: begin
				if (draw_valid) state_nxt = rmf_pkg::ST_DIV;
			end
			rmf_pkg::ST_DIV: begin
				if (stat.div_done) state_nxt = rmf_pkg::ST_PICK;
			end
			rmf_pkg::ST_PICK: state_nxt = rmf_pkg::ST_SEL;
			rmf_pkg::ST_SEL: state_nxt = rmf_pkg::ST_SHIFT;
			rmf_pkg::ST_SHIFT: begin
				if (stat.shift_done) state_nxt = rmf_pkg::ST_EMIT;
			end
			rmf_pkg::ST_EMIT: begin
				if (can_emit) begin
					state_nxt = stat.emit_last ? rmf_pkg::ST_START : rmf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rmf_pkg::ST_START;
		endcase
		// a side write restarts the list for the new side
		if (cfg_wr) state_nxt = rmf_pkg::ST_START;
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			rmf_pkg::ST_START: cmd.fill_start = 1'b1;
			rmf_pkg::ST_FILL:  cmd.fill_step  = 1'b1;
			rmf_pkg::ST_IDLE:  cmd.load       = draw_valid && !cfg_wr;
			rmf_pkg::ST_DIV:   cmd.div_step   = 1'b1;
			rmf_pkg::ST_PICK:  cmd.read_pick  = 1'b1;
			rmf_pkg::ST_SEL:   cmd.hold_pick  = 1'b1;
			rmf_pkg::ST_SHIFT: cmd.shift_step = 1'b1;
			rmf_pkg::ST_EMIT:  cmd.emit       = can_emit;
			default:           cmd            = '0;
		endcase
	end

	assign draw_stall = (state_q != rmf_pkg::ST_IDLE) || cfg_wr;

endmodule

// ----- rtl/rmf_dp.sv -----
// Cell list memory, list generator, restoring remainder unit, counters and result register.
module rmf_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rmf_pkg::SIDE_W-1:0]   side,
	input  rmf_pkg::dp_cmd_t             cmd,
	input  logic [rmf_pkg::WORD_W-1:0]   random_word,
	input  logic                         cell_stall,
	output rmf_pkg::dp_stat_t            stat,
	output logic                         cell_valid,
	output logic [rmf_pkg::COORD_W-1:0]  row,
	output logic [rmf_pkg::COORD_W-1:0]  col,
	output logic [rmf_pkg::SIDE_W-1:0]   value,
	output logic                         last_draw
);

	// cell list: {row, col} per entry
	logic [rmf_pkg::ENTRY_W-1:0] mem [rmf_pkg::DEPTH];
	logic [rmf_pkg::ENTRY_W-1:0] rdata_q;
	logic [rmf_pkg::ADDR_W-1:0]  raddr;
	logic [rmf_pkg::ADDR_W-1:0]  waddr;
	logic [rmf_pkg::ENTRY_W-1:0] wdata;
	logic                        we;

	logic [2*rmf_pkg::SIDE_W-1:0] total_w;
	logic [rmf_pkg::CNT_W-1:0]    total;
	logic [rmf_pkg::SIDE_W-1:0]   side_m1;

	// list generator
	logic [rmf_pkg::DIAG_W-1:0]  fd_q;
	logic [rmf_pkg::COORD_W-1:0] fr_q;
	logic [rmf_pkg::ADDR_W-1:0]  fpos_q;
	logic [rmf_pkg::DIAG_W-1:0]  diag_last;
	logic [rmf_pkg::DIAG_W-1:0]  bottom;
	logic [rmf_pkg::DIAG_W-1:0]  fd_inc;
	logic [rmf_pkg::DIAG_W-1:0]  fcol;

	// remainder unit
	logic [rmf_pkg::CNT_W-1:0]   rem_q;
	logic [rmf_pkg::WORD_W-1:0]  dvd_q;
	logic [rmf_pkg::BIT_W-1:0]   bit_q;
	logic [rmf_pkg::CNT_W-1:0]   remaining_q;
	logic [rmf_pkg::CNT_W:0]     trial;
	logic [rmf_pkg::CNT_W:0]     trial_sub;
	logic                        trial_ge;

	// gap close
	logic [rmf_pkg::CNT_W-1:0]   addr_q;
	logic                        more_rd;
	logic                        sv_s1;
	logic [rmf_pkg::ADDR_W-1:0]  waddr_s1;
	logic [rmf_pkg::ENTRY_W-1:0] pick_q;

	// draw counters
	logic [rmf_pkg::CNT_W-1:0]   draws_q;
	logic [rmf_pkg::CNT_W-1:0]   draws_inc;
	logic [rmf_pkg::SIDE_W-1:0]  grp_q;
	logic [rmf_pkg::SIDE_W-1:0]  grp_inc;
	logic [rmf_pkg::SIDE_W-1:0]  val_q;

	// result register
	logic                        cell_valid_q;
	logic [rmf_pkg::ENTRY_W-1:0] o_cell_q;
	logic [rmf_pkg::SIDE_W-1:0]  o_val_q;
	logic                        o_last_q;

	assign total_w = side * side;
	assign total   = total_w[rmf_pkg::CNT_W-1:0];
	assign side_m1 = side - rmf_pkg::SIDE_W'(1);

	// anti-diagonal walk, row descending within a diagonal
	assign diag_last = {side_m1[rmf_pkg::SIDE_W-2:0], 1'b0};
	assign bottom    = (fd_q >= side) ? (fd_q - side_m1) : '0;
	assign fd_inc    = fd_q + rmf_pkg::DIAG_W'(1);
	assign fcol      = fd_q - {1'b0, fr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_q   <= '0;
			fr_q   <= '0;
			fpos_q <= '0;
		end else if (cmd.fill_start) begin
			fd_q   <= '0;
			fr_q   <= '0;
			fpos_q <= '0;
		end else if (cmd.fill_step) begin
			fpos_q <= fpos_q + rmf_pkg::ADDR_W'(1);
			if ({1'b0, fr_q} > bottom) begin
				fr_q <= fr_q - rmf_pkg::COORD_W'(1);
			end else begin
				fd_q <= fd_inc;
				fr_q <= (fd_inc < side) ? fd_inc[rmf_pkg::COORD_W-1:0]
				                        : side_m1[rmf_pkg::COORD_W-1:0];
			end
		end
	end

	// restoring remainder, one bit per cycle
	assign trial     = {rem_q, dvd_q[rmf_pkg::WORD_W-1]};
	assign trial_ge  = trial >= {1'b0, remaining_q};
	assign trial_sub = trial - {1'b0, remaining_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q       <= '0;
			dvd_q       <= random_word;
			bit_q       <= '0;
			remaining_q <= total - draws_q;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[rmf_pkg::CNT_W-1:0] : trial[rmf_pkg::CNT_W-1:0];
			dvd_q <= {dvd_q[rmf_pkg::WORD_W-2:0], 1'b0};
			bit_q <= bit_q + rmf_pkg::BIT_W'(1);
		end
	end

	// walk entries above the pick down by one
	assign more_rd = addr_q < remaining_q;

	always_ff @(posedge clk) begin
		if (cmd.read_pick) begin
			addr_q <= {1'b0, rem_q[rmf_pkg::ADDR_W-1:0]} + rmf_pkg::CNT_W'(1);
		end else if (cmd.shift_step && more_rd) begin
			addr_q <= addr_q + rmf_pkg::CNT_W'(1);
		end
		waddr_s1 <= addr_q[rmf_pkg::ADDR_W-1:0] - rmf_pkg::ADDR_W'(1);
		if (cmd.hold_pick) begin
			pick_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s1 <= 1'b0;
		end else begin
			sv_s1 <= cmd.shift_step && more_rd;
		end
	end

	// memory ports
	assign raddr = cmd.read_pick ? rem_q[rmf_pkg::ADDR_W-1:0] : addr_q[rmf_pkg::ADDR_W-1:0];
	assign we    = cmd.fill_step || sv_s1;
	assign waddr = cmd.fill_step ? fpos_q : waddr_s1;
	assign wdata = cmd.fill_step ? {fr_q, fcol[rmf_pkg::COORD_W-1:0]} : rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// draws done and value, value steps every side draws
	assign draws_inc = draws_q + rmf_pkg::CNT_W'(1);
	assign grp_inc   = grp_q + rmf_pkg::SIDE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draws_q <= '0;
			grp_q   <= '0;
			val_q   <= rmf_pkg::SIDE_W'(1);
		end else if (cmd.fill_start) begin
			draws_q <= '0;
			grp_q   <= '0;
			val_q   <= rmf_pkg::SIDE_W'(1);
		end else if (cmd.emit) begin
			draws_q <= draws_inc;
			if (grp_inc == side) begin
				grp_q <= '0;
				val_q <= val_q + rmf_pkg::SIDE_W'(1);
			end else begin
				grp_q <= grp_inc;
			end
		end
	end

	// result register, freed by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			cell_valid_q <= 1'b1;
		end else if (!cell_stall) begin
			cell_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_cell_q <= pick_q;
			o_val_q  <= val_q;
			o_last_q <= stat.emit_last;
		end
	end

	assign stat.fill_done  = (fd_q == diag_last) && ({1'b0, fr_q} == bottom);
	assign stat.div_done   = bit_q == rmf_pkg::BIT_W'(rmf_pkg::WORD_W - 1);
	assign stat.shift_done = !more_rd && !sv_s1;
	assign stat.out_full   = cell_valid_q;
	assign stat.out_taken  = cell_valid_q && !cell_stall;
	assign stat.emit_last  = draws_inc == total;

	assign cell_valid = cell_valid_q;
	assign row        = o_cell_q[rmf_pkg::ENTRY_W-1:rmf_pkg::COORD_W];
	assign col        = o_cell_q[rmf_pkg::COORD_W-1:0];
	assign value      = o_val_q;
	assign last_draw  = o_last_q;

endmodule

// ----- rtl/random_matrix_fill_by_draw_core.sv -----
// Random matrix fill: each draw takes one random word and returns one still unfilled cell
// of an n-by-n matrix together with its value, so that every value 1..n lands in exactly n
// cells. From a draw transfer to a valid result, the bit-serial remainder unit first reduces
// the word (random_word mod remaining cells), then the picked list entry is read through a
// registered read, then the gap close moves each list entry above the pick down by one
// through the single write port of the list memory, and last the result register is loaded.
// The next draw can transfer at the earliest as soon as the result is loaded. The result
// register holds a finished cell until it is transferred, while the next draw is already
// accepted. After reset, after any write to matrix_side and after the draw that raises
// last_draw, the list is reloaded in anti-diagonal order (the default side after reset is
// 4), during which draws are stalled. A side of 0 acts as 1 and one above 16 acts as 16.
// The side register sits at byte address 0 of the APB port.
module random_matrix_fill_by_draw_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rmf_pkg::PADDR_W-1:0]   paddr,
	input  logic [rmf_pkg::PDATA_W-1:0]   pwdata,
	output logic [rmf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// draw channel
	input  logic                          draw_valid,
	output logic                          draw_stall,
	input  logic [rmf_pkg::WORD_W-1:0]    random_word,
	// cell channel
	output logic                          cell_valid,
	input  logic                          cell_stall,
	output logic [rmf_pkg::COORD_W-1:0]   row,
	output logic [rmf_pkg::COORD_W-1:0]   col,
	output logic [rmf_pkg::SIDE_W-1:0]    value,
	output logic                          last_draw
);

	logic [rmf_pkg::SIDE_W-1:0] side_q;
	logic [rmf_pkg::SIDE_W-1:0] side_eff;
	logic                       side_sel;
	logic                       cfg_wr;
	rmf_pkg::dp_cmd_t           cmd;
	rmf_pkg::dp_stat_t          stat;

	// register decode
	assign side_sel = paddr[rmf_pkg::PADDR_W-1:2] == rmf_pkg::REG_MATRIX_SIDE;
	assign cfg_wr   = psel && penable && pwrite && pready && side_sel;
	assign pready   = 1'b1;
	assign prdata   = side_sel ? {{(rmf_pkg::PDATA_W - rmf_pkg::SIDE_W){1'b0}}, side_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= rmf_pkg::SIDE_RESET;
		end else if (cfg_wr) begin
			side_q <= pwdata[rmf_pkg::SIDE_W-1:0];
		end
	end

	// clamp side to 1..MAX_SIDE
	always_comb begin
		if (side_q == '0) begin
			side_eff = rmf_pkg::SIDE_W'(1);
		end else if (side_q > rmf_pkg::SIDE_W'(rmf_pkg::MAX_SIDE)) begin
			side_eff = rmf_pkg::SIDE_W'(rmf_pkg::MAX_SIDE);
		end else begin
			side_eff = side_q;
		end
	end

	rmf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.draw_valid (draw_valid),
		.stat       (stat),
		.draw_stall (draw_stall),
		.cmd        (cmd)
	);

	rmf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.side        (side_eff),
		.cmd         (cmd),
		.random_word (random_word),
		.cell_stall  (cell_stall),
		.stat        (stat),
		.cell_valid  (cell_valid),
		.row         (row),
		.col         (col),
		.value       (value),
		.last_draw   (last_draw)
	);

endmodule

// ----- rtl/rmf_checker.sv -----
// Port-level checks for the random matrix fill core, bound to the top level.
module rmf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [rmf_pkg::PADDR_W-1:0]   paddr,
	input logic                          pready,
	input logic                          draw_valid,
	input logic                          draw_stall,
	input logic                          cell_valid,
	input logic                          cell_stall,
	input logic [rmf_pkg::COORD_W-1:0]   row,
	input logic [rmf_pkg::COORD_W-1:0]   col,
	input logic [rmf_pkg::SIDE_W-1:0]    value,
	input logic                          last_draw
);

	// hold a stalled cell transfer
	a_cell_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && cell_stall |=> cell_valid && $stable(row) && $stable(col)
		&& $stable(value) && $stable(last_draw))
		else $error("stalled cell transfer changed");

	// one draw at a time: the remainder unit is busy after a transfer
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		draw_valid && !draw_stall |=> draw_stall ##1 draw_stall)
		else $error("draw accepted while previous draw in progress");

	// a side write starts a reload
	a_cfg_reload: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[rmf_pkg::PADDR_W-1:2] == '0)
		|=> draw_stall)
		else $error("draw not stalled after side write");

	// value stays in 1..MAX_SIDE
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> (value != '0) && (value <= rmf_pkg::SIDE_W'(rmf_pkg::MAX_SIDE)))
		else $error("cell value out of range");

endmodule

bind random_matrix_fill_by_draw_core rmf_checker u_rmf_checker (.*);
